### rtl/core/hpt_pkg.sv
// Package for the Hall pulse tachometer: sizes, register map, reset values, state type.
package hpt_pkg;

    localparam int HPT_HISTORY_LEN = 32;
    localparam int HPT_NUM_SENSORS = 2;
    localparam int HPT_TIME_BITS   = 48;

    // APB register map (word index taken from paddr[3:2])
    localparam int CFG_ADDR_W = 4;
    localparam logic [1:0] REG_MIN_GAP = 2'd0;
    localparam logic [1:0] REG_CUTOFF  = 2'd1;
    localparam logic [1:0] REG_PPR     = 2'd2;

    localparam logic [31:0] MIN_GAP_RST = 32'd1000;
    localparam logic [31:0] CUTOFF_RST  = 32'd1000000;
    localparam logic [7:0]  PPR_RST     = 8'd1;

    // 60e6 us/min * 256 (Q24.8)
    localparam int          SCALE_W   = 34;
    localparam logic [SCALE_W-1:0] RPM_SCALE = 34'd15360000000;

    localparam logic FUNC_PULSE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_NEW,
        ST_EVAL,
        ST_RD_OLD,
        ST_SPAN,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } hpt_state_t;

endpackage

### rtl/core/hpt_in_if.sv
// Request channel carrying pulse and query items into the tachometer.
interface hpt_in_if
    import hpt_pkg::*;
#(
    parameter int TIME_BITS = HPT_TIME_BITS
) ();
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic                 sensor;
    logic [TIME_BITS-1:0] timestamp_us;
    logic [5:0]           avg_count;

    modport source (output valid, func, sensor, timestamp_us, avg_count, input ready);
    modport sink   (input valid, func, sensor, timestamp_us, avg_count, output ready);
endinterface

### rtl/core/hpt_out_if.sv
// Result channel carrying one tachometer result per request.
interface hpt_out_if
    import hpt_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [31:0] rpm_q8;
    logic        pulse_accepted;
    logic        motor_stopped;
    logic        too_few_pulses;

    modport source (output valid, rpm_q8, pulse_accepted, motor_stopped, too_few_pulses,
                    input ready);
    modport sink   (input valid, rpm_q8, pulse_accepted, motor_stopped, too_few_pulses,
                    output ready);
endinterface

### rtl/core/hall_pulse_tachometer.sv
// Top level of the two-channel Hall pulse-period tachometer with noise gate.
// in_ch  (valid/ready request channel): func=0 is a pulse edge on channel
//        `sensor` at timestamp_us; func=1 is an RPM query at time
//        timestamp_us averaging over avg_count pulses (clamped 2..HISTORY_LEN).
// out_ch (valid/ready): exactly one result per request, in order.
// APB port: noise-gate minimum gap @0x0, cutoff_us @0x4, pulses per
//        revolution @0x8; write only while idle. pready is tied high.
// Sequencing, output register free:
//   One request at a time; in_ch.ready is high only in the idle state, which
//   comes back in the same cycle that out_ch.valid rises.
//   Pulse: states RD_NEW, EVAL and DONE after acceptance.
//   Query: RD_NEW, EVAL, RD_OLD, SPAN, MUL, DIV and DONE; in DIV the bit-serial
//   divider works on a numerator of NUM_W = 34 + clog2(HISTORY_LEN+1) bits
//   at one quotient bit per cycle. A query with too few pulses or a stopped
//   motor ends after EVAL like a pulse, a zero span after SPAN.
// Stall: a finished result sits in the output register; the next request is
//   taken meanwhile, and its result waits in the done state (input stalled)
//   until out_ch frees the output register.
// Reset: rst_n (async, active low) clears the per-channel write pointers and
//   fill counts and restores register defaults; the timestamp memory is not
//   cleared, since fill counts keep unwritten entries from ever being used.
module hall_pulse_tachometer
    import hpt_pkg::*;
#(
    parameter int HISTORY_LEN = HPT_HISTORY_LEN,
    parameter int NUM_SENSORS = HPT_NUM_SENSORS,
    parameter int TIME_BITS   = HPT_TIME_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    hpt_in_if.sink                in_ch,
    hpt_out_if.source             out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    localparam int PW    = $clog2(HISTORY_LEN);          // write pointer
    localparam int FW    = $clog2(HISTORY_LEN + 1);      // fill count / pulse count
    localparam int CH_W  = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int DEPTH = NUM_SENSORS * HISTORY_LEN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NUM_W = SCALE_W + FW;
    localparam int DEN_W = TIME_BITS + 8;

    // ---------------- configuration registers ----------------
    logic [31:0] min_gap_reg;
    logic [31:0] cutoff_reg;
    logic [7:0]  ppr_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_reg <= MIN_GAP_RST;
            cutoff_reg  <= CUTOFF_RST;
            ppr_reg     <= PPR_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_MIN_GAP: min_gap_reg <= pwdata;
                REG_CUTOFF:  cutoff_reg  <= pwdata;
                REG_PPR:     ppr_reg     <= pwdata[7:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MIN_GAP: prdata = min_gap_reg;
            REG_CUTOFF:  prdata = cutoff_reg;
            REG_PPR:     prdata = {24'd0, ppr_reg};
            default:     prdata = '0;
        endcase
    end

    // ---------------- request capture and per-channel state ----------------
    hpt_state_t state_reg, state_next;

    logic                 func_reg;
    logic [CH_W-1:0]      ch_reg;
    logic [TIME_BITS-1:0] t_reg;
    logic [FW-1:0]        n_reg;      // clamped averaging count
    logic [FW-1:0]        use_reg;    // pulses actually used
    logic [TIME_BITS-1:0] newest_reg;
    logic [TIME_BITS-1:0] span_reg;

    logic [PW-1:0] wp_reg   [NUM_SENSORS];
    logic [FW-1:0] fill_reg [NUM_SENSORS];

    logic          in_acc;
    logic          in_ch_ok;
    logic [FW-1:0] n_clamp;

    assign in_acc   = in_ch.valid && in_ch.ready;
    assign in_ch_ok = (32'(in_ch.sensor) < NUM_SENSORS);

    always_comb
    begin
        if (in_ch.avg_count < 6'd2)
            n_clamp = FW'(2);
        else if (32'(in_ch.avg_count) > HISTORY_LEN)
            n_clamp = FW'(HISTORY_LEN);
        else
            n_clamp = FW'(in_ch.avg_count);
    end

    logic [PW-1:0] cur_wp;
    logic [FW-1:0] cur_fill;
    logic [FW-1:0] wp_ext;
    logic [PW-1:0] newest_idx;
    logic [PW-1:0] oldest_idx;
    logic [PW-1:0] wp_inc;

    assign cur_wp   = wp_reg[ch_reg];
    assign cur_fill = fill_reg[ch_reg];
    assign wp_ext   = FW'(cur_wp);

    assign newest_idx = (cur_wp == '0) ? PW'(HISTORY_LEN - 1) : cur_wp - PW'(1);
    assign oldest_idx = (wp_ext >= use_reg) ? PW'(wp_ext - use_reg)
                                            : PW'(wp_ext + FW'(HISTORY_LEN) - use_reg);
    assign wp_inc     = (cur_wp == PW'(HISTORY_LEN - 1)) ? '0 : cur_wp + PW'(1);

    // ---------------- timestamp memory ----------------
    logic [TIME_BITS-1:0] mem [DEPTH];
    logic [TIME_BITS-1:0] rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        ch_base;
    logic                 mem_we;

    assign ch_base = AW'(ch_reg) * AW'(HISTORY_LEN);
    assign wr_addr = ch_base + AW'(cur_wp);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= t_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // ---------------- evaluation datapath ----------------
    logic [TIME_BITS-1:0] gap;        // also the age for a query
    logic [TIME_BITS-1:0] span;
    logic                 gate_reject;
    logic                 too_old;
    logic                 few_held;
    logic [7:0]           ppr_eff;
    logic [NUM_W-1:0]     num_prod;
    logic [DEN_W-1:0]     den_prod;

    assign gap         = t_reg - rd_data_reg;
    assign span        = newest_reg - rd_data_reg;
    assign gate_reject = (cur_fill != '0) && (gap < TIME_BITS'(min_gap_reg));
    assign too_old     = (gap > TIME_BITS'(cutoff_reg));
    assign few_held    = (cur_fill < FW'(2));
    assign ppr_eff     = (ppr_reg == '0) ? 8'd1 : ppr_reg;
    // floor(floor(a/b)/c) == floor(a/(b*c)), so one division does both steps
    assign num_prod    = NUM_W'(RPM_SCALE) * NUM_W'(use_reg - FW'(1));
    assign den_prod    = DEN_W'(span_reg) * DEN_W'(ppr_eff);

    logic             div_start;
    logic             div_busy;
    logic             div_done;
    logic [NUM_W-1:0] div_quot;

    hpt_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_prod),
        .den   (den_prod),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    // ---------------- sequencer ----------------
    logic out_valid_reg;
    logic out_free;

    assign out_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                    state_next = in_ch_ok ? ST_RD_NEW : ST_DONE;
            end
            ST_RD_NEW: state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (func_reg == FUNC_PULSE || few_held || too_old)
                    state_next = ST_DONE;
                else
                    state_next = ST_RD_OLD;
            end
            ST_RD_OLD: state_next = ST_SPAN;
            ST_SPAN:   state_next = (span == '0) ? ST_DONE : ST_MUL;
            ST_MUL:    state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ch.ready = 1'b0;
        mem_we      = 1'b0;
        div_start   = 1'b0;
        rd_addr     = ch_base + AW'(newest_idx);
        case (state_reg)
            ST_IDLE:   in_ch.ready = 1'b1;
            ST_RD_NEW: rd_addr = ch_base + AW'(newest_idx);
            ST_EVAL:   mem_we = (func_reg == FUNC_PULSE) && !gate_reject;
            ST_RD_OLD: rd_addr = ch_base + AW'(oldest_idx);
            ST_MUL:    div_start = 1'b1;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                wp_reg[i]   <= '0;
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (mem_we)
            begin
                wp_reg[ch_reg] <= wp_inc;
                if (cur_fill < FW'(HISTORY_LEN))
                    fill_reg[ch_reg] <= cur_fill + FW'(1);
            end
        end
    end

    // result held here until the output register frees up
    logic [31:0] res_rpm_reg;
    logic        res_acc_reg;
    logic        res_stop_reg;
    logic        res_few_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    func_reg     <= in_ch.func;
                    ch_reg       <= CH_W'(in_ch.sensor);
                    t_reg        <= in_ch.timestamp_us;
                    n_reg        <= n_clamp;
                    res_rpm_reg  <= '0;
                    res_acc_reg  <= 1'b0;
                    res_stop_reg <= 1'b0;
                    // out-of-range channel: pulse dropped, query reports too few
                    res_few_reg  <= !in_ch_ok && (in_ch.func == FUNC_QUERY);
                end
            end
            ST_EVAL:
            begin
                newest_reg <= rd_data_reg;
                use_reg    <= (cur_fill < n_reg) ? cur_fill : n_reg;
                if (func_reg == FUNC_PULSE)
                    res_acc_reg <= !gate_reject;
                else if (few_held)
                    res_few_reg <= 1'b1;
                else if (too_old)
                    res_stop_reg <= 1'b1;
            end
            ST_SPAN:
            begin
                span_reg <= span;
                if (span == '0)
                    res_few_reg <= 1'b1;
            end
            ST_DIV:
            begin
                if (div_done)
                    res_rpm_reg <= (|div_quot[NUM_W-1:32]) ? '1 : div_quot[31:0];
            end
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    logic [31:0] out_rpm_reg;
    logic        out_acc_reg;
    logic        out_stop_reg;
    logic        out_few_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            out_rpm_reg  <= res_rpm_reg;
            out_acc_reg  <= res_acc_reg;
            out_stop_reg <= res_stop_reg;
            out_few_reg  <= res_few_reg;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.rpm_q8         = out_rpm_reg;
    assign out_ch.pulse_accepted = out_acc_reg;
    assign out_ch.motor_stopped  = out_stop_reg;
    assign out_ch.too_few_pulses = out_few_reg;

    // ---------------- assertions ----------------
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ch.ready)
        else $error("tachometer took a request while busy");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0({out_acc_reg, out_stop_reg, out_few_reg}))
        else $error("more than one status flag in a result");

    a_rpm_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_rpm_reg != '0) |-> !(out_acc_reg || out_stop_reg || out_few_reg))
        else $error("nonzero rpm with a status flag");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (!div_busy && use_reg >= FW'(2)))
        else $error("divider started while busy or with fewer than two pulses");

endmodule

### rtl/core/hpt_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
module hpt_div
    import hpt_pkg::*;
#(
    parameter int NUM_W = 40,
    parameter int DEN_W = 56
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W:0]   rem_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] den_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_shift;
    logic             ge;

    // numerator bits shift out of q_reg's top while quotient bits enter its bottom
    assign rem_shift = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};
    assign ge        = (rem_shift >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(NUM_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            q_reg   <= num;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? (rem_shift - {1'b0, den_reg}) : rem_shift;
            q_reg   <= {q_reg[NUM_W-2:0], ge};
        end
    end

    assign busy = (cnt_reg != '0);
    assign done = done_reg;
    assign quot = q_reg;

endmodule
